// File: src/btms_pkg.sv
`default_nettype none
package btms_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [TIME_W-1:0] DISARMED = '1;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_OFF   = 3'd1,
    MODE_LOW   = 3'd2,
    MODE_MED   = 3'd3,
    MODE_OVER  = 3'd4,
    MODE_BRAKE = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MS  = 3'd0,
    REG_LONG_MS   = 3'd1,
    REG_LOW_PCT   = 3'd2,
    REG_MED_PCT   = 3'd3,
    REG_OVER_PCT  = 3'd4,
    REG_BRAKE_PCT = 3'd5,
    REG_BRAKE_EN  = 3'd6
  } cfg_reg_t;

  localparam logic [15:0] RST_SHORT_MS = 16'd1000;
  localparam logic [15:0] RST_LONG_MS = 16'd3000;
  localparam logic [6:0] RST_LOW_PCT = 7'd30;
  localparam logic [6:0] RST_MED_PCT = 7'd60;
  localparam logic [6:0] RST_OVER_PCT = 7'd100;
  localparam logic signed [7:0] RST_BRAKE_PCT = -8'sd100;

  typedef struct packed {
    logic [15:0]       short_ms;
    logic [15:0]       long_ms;
    logic [6:0]        low_pct;
    logic [6:0]        med_pct;
    logic [6:0]        over_pct;
    logic signed [7:0] brake_pct;
    logic              brake_en;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              button_press_edge;
    logic              button_release_edge;
    logic              brake_press_edge;
    logic              brake_release_edge;
  } item_t;

  typedef struct packed {
    mode_t             cur_mode;
    mode_t             saved_mode;
    logic [TIME_W-1:0] short_dl;
    logic [TIME_W-1:0] long_dl;
    logic [7:0]        last_pct;
  } state_t;

  typedef struct packed {
    mode_t             mode;
    logic signed [7:0] throttle_percent;
    logic              output_changed;
  } result_t;

endpackage
`default_nettype wire

// File: src/btms_cfg.sv
`default_nettype none
module btms_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [btms_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [btms_pkg::CFG_DATA_W-1:0]    wr_data,
  output btms_pkg::cfg_t                          cfg
);
  import btms_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ms  <= RST_SHORT_MS;
      cfg_r.long_ms   <= RST_LONG_MS;
      cfg_r.low_pct   <= RST_LOW_PCT;
      cfg_r.med_pct   <= RST_MED_PCT;
      cfg_r.over_pct  <= RST_OVER_PCT;
      cfg_r.brake_pct <= RST_BRAKE_PCT;
      cfg_r.brake_en  <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_SHORT_MS:  cfg_r.short_ms  <= wr_data;
        REG_LONG_MS:   cfg_r.long_ms   <= wr_data;
        REG_LOW_PCT:   cfg_r.low_pct   <= wr_data[6:0];
        REG_MED_PCT:   cfg_r.med_pct   <= wr_data[6:0];
        REG_OVER_PCT:  cfg_r.over_pct  <= wr_data[6:0];
        REG_BRAKE_PCT: cfg_r.brake_pct <= wr_data[7:0];
        REG_BRAKE_EN:  cfg_r.brake_en  <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: src/btms_step.sv
`default_nettype none
module btms_step (
  input  wire btms_pkg::cfg_t    cfg,
  input  wire btms_pkg::item_t   item,
  input  wire btms_pkg::state_t  state,
  output btms_pkg::state_t       state_nxt,
  output btms_pkg::result_t      result
);
  import btms_pkg::*;

  function automatic logic [7:0] pct_of(input mode_t m, input cfg_t c);
    logic [7:0] p;
    case (m)
      MODE_LOW:   p = {1'b0, c.low_pct};
      MODE_MED:   p = {1'b0, c.med_pct};
      MODE_OVER:  p = {1'b0, c.over_pct};
      MODE_BRAKE: p = c.brake_pct;
      default:    p = 8'd0;
    endcase
    return p;
  endfunction

  function automatic mode_t step_mode(input mode_t m);
    mode_t r;
    case (m)
      MODE_NONE: r = MODE_OFF;
      MODE_OFF:  r = MODE_LOW;
      MODE_LOW:  r = MODE_MED;
      MODE_MED:  r = MODE_OVER;
      default:   r = MODE_NONE;
    endcase
    return r;
  endfunction

  always_comb begin
    state_t     s;
    logic       wrote;
    logic       skip;
    logic [7:0] p;
    s     = state;
    wrote = 1'b0;
    skip  = 1'b0;
    p     = 8'd0;

    if (cfg.brake_en) begin
      if (item.brake_press_edge) begin
        s.short_dl = DISARMED;
        s.long_dl  = DISARMED;
        if (s.cur_mode == MODE_OVER) begin
          s.cur_mode = s.saved_mode;
        end
        s.saved_mode = s.cur_mode;
        s.cur_mode   = MODE_BRAKE;
        p = pct_of(s.cur_mode, cfg);
        if (p != s.last_pct) begin
          s.last_pct = p;
          wrote      = 1'b1;
        end
      end
      if (item.brake_release_edge) begin
        s.cur_mode   = s.saved_mode;
        s.saved_mode = MODE_NONE;
        p = pct_of(s.cur_mode, cfg);
        if (p != s.last_pct) begin
          s.last_pct = p;
          wrote      = 1'b1;
        end
      end
      skip = (s.cur_mode == MODE_BRAKE);
    end

    if (!skip) begin
      if (item.button_press_edge) begin
        s.short_dl = item.now_ms + {16'd0, cfg.short_ms};
        s.long_dl  = item.now_ms + {16'd0, cfg.long_ms};
      end
      if (item.button_release_edge) begin
        if (s.saved_mode == MODE_NONE) begin
          s.cur_mode = MODE_OFF;
        end
        if (s.cur_mode == MODE_OVER) begin
          s.cur_mode = s.saved_mode;
        end
        s.saved_mode = MODE_NONE;
        s.short_dl   = DISARMED;
        s.long_dl    = DISARMED;
      end
      if (s.saved_mode == MODE_NONE && item.now_ms > s.short_dl) begin
        s.saved_mode = s.cur_mode;
        s.cur_mode   = step_mode(s.cur_mode);
        if (s.cur_mode == MODE_OVER) begin
          s.cur_mode = MODE_MED;
        end
      end
      if (s.cur_mode != MODE_OVER && item.now_ms > s.long_dl) begin
        s.cur_mode = MODE_OVER;
      end
      p = pct_of(s.cur_mode, cfg);
      if (p != s.last_pct) begin
        s.last_pct = p;
        wrote      = 1'b1;
      end
    end

    state_nxt               = s;
    result.mode             = s.cur_mode;
    result.throttle_percent = pct_of(s.cur_mode, cfg);
    result.output_changed   = wrote;
  end

endmodule
`default_nettype wire

// File: src/button_throttle_mode_selector.sv
// A result passes through the input register and then the output register.
// Throughput: one item per cycle while the result side does not stall; the mode state updates in one pass.
// A stalled result holds the output register; the input register takes one more
// item and then the input stalls until the result transfers.
// Reset (synchronous, active low) restores the register defaults, sets the mode
// to off, disarms both deadlines and empties the pipeline.
`default_nettype none
module button_throttle_mode_selector (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [btms_pkg::TIME_W-1:0]      in_now_ms,
  input  wire logic                             in_button_press_edge,
  input  wire logic                             in_button_release_edge,
  input  wire logic                             in_brake_press_edge,
  input  wire logic                             in_brake_release_edge,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [2:0]                            out_mode,
  output logic signed [7:0]                     out_throttle_percent,
  output logic                                  out_output_changed,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [btms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [btms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import btms_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    out_take;
  logic    in_take;
  logic    advance;

  assign cfg_ready = 1'b1;

  btms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  btms_step u_step (
    .cfg       (cfg),
    .item      (item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  assign out_take = !out_valid_r || !out_stall;
  assign advance  = item_valid_r && out_take;
  assign in_stall = item_valid_r && !out_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.now_ms              <= in_now_ms;
      item_r.button_press_edge   <= in_button_press_edge;
      item_r.button_release_edge <= in_button_release_edge;
      item_r.brake_press_edge    <= in_brake_press_edge;
      item_r.brake_release_edge  <= in_brake_release_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.cur_mode   <= MODE_OFF;
      state_r.saved_mode <= MODE_NONE;
      state_r.short_dl   <= DISARMED;
      state_r.long_dl    <= DISARMED;
      state_r.last_pct   <= 8'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mode             = res_r.mode;
  assign out_throttle_percent = res_r.throttle_percent;
  assign out_output_changed   = res_r.output_changed;

endmodule
`default_nettype wire

// File: src/btms_checker.sv
`default_nettype none
module btms_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [2:0]        out_mode,
  input wire logic signed [7:0] out_throttle_percent,
  input wire logic              out_output_changed
);
  import btms_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result channel is not empty after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode)
      && $stable(out_throttle_percent) && $stable(out_output_changed))
    else $error("Stalled result changed.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the result side can take a transfer.");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode == MODE_NONE || out_mode == MODE_OFF)
      |-> out_throttle_percent == 8'sd0)
    else $error("Off or none mode shows a nonzero throttle percent.");

endmodule

bind button_throttle_mode_selector btms_checker u_btms_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_mode             (out_mode),
  .out_throttle_percent (out_throttle_percent),
  .out_output_changed   (out_output_changed)
);
`default_nettype wire

// File: verif/button_throttle_mode_selector_tb.sv
module button_throttle_mode_selector_tb;
  import btms_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic in_button_press_edge = 1'b0;
  logic in_button_release_edge = 1'b0;
  logic in_brake_press_edge = 1'b0;
  logic in_brake_release_edge = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_mode;
  logic signed [7:0] out_throttle_percent;
  logic out_output_changed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t sel_cfg;
  mode_t cur_mode;
  mode_t held_mode;
  logic [TIME_W-1:0] short_due;
  logic [TIME_W-1:0] long_due;
  logic [7:0] last_pct;

  result_t predicted_outputs[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  logic idle_on = 1'b1;
  logic hold_request = 1'b0;
  logic [TIME_W-1:0] clk_ms = '0;

  button_throttle_mode_selector i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_now_ms              (in_now_ms),
    .in_button_press_edge   (in_button_press_edge),
    .in_button_release_edge (in_button_release_edge),
    .in_brake_press_edge    (in_brake_press_edge),
    .in_brake_release_edge  (in_brake_release_edge),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_mode               (out_mode),
    .out_throttle_percent   (out_throttle_percent),
    .out_output_changed     (out_output_changed),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[button_throttle_mode_selector] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] pct_of(mode_t m);
    case (m)
      MODE_LOW: return {1'b0, sel_cfg.low_pct};
      MODE_MED: return {1'b0, sel_cfg.med_pct};
      MODE_OVER: return {1'b0, sel_cfg.over_pct};
      MODE_BRAKE: return sel_cfg.brake_pct;
      default: return 8'd0;
    endcase
  endfunction

  function automatic mode_t stepped(mode_t m);
    case (m)
      MODE_NONE: return MODE_OFF;
      MODE_OFF: return MODE_LOW;
      MODE_LOW: return MODE_MED;
      MODE_MED: return MODE_OVER;
      default: return MODE_NONE;
    endcase
  endfunction

  function automatic logic latch_percent();
    logic [7:0] p;
    p = pct_of(cur_mode);
    if (p != last_pct) begin
      last_pct = p;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_selector(item_t p);
    result_t r;
    logic skip_buttons;
    logic changed;
    skip_buttons = 1'b0;
    changed = 1'b0;
    if (sel_cfg.brake_en) begin
      if (p.brake_press_edge) begin
        short_due = DISARMED;
        long_due = DISARMED;
        if (cur_mode == MODE_OVER) cur_mode = held_mode;
        held_mode = cur_mode;
        cur_mode = MODE_BRAKE;
        changed |= latch_percent();
      end
      if (p.brake_release_edge) begin
        cur_mode = held_mode;
        held_mode = MODE_NONE;
        changed |= latch_percent();
      end
      if (cur_mode == MODE_BRAKE) skip_buttons = 1'b1;
    end
    if (!skip_buttons) begin
      if (p.button_press_edge) begin
        short_due = p.now_ms + {16'd0, sel_cfg.short_ms};
        long_due = p.now_ms + {16'd0, sel_cfg.long_ms};
      end
      if (p.button_release_edge) begin
        if (held_mode == MODE_NONE) cur_mode = MODE_OFF;
        if (cur_mode == MODE_OVER) cur_mode = held_mode;
        held_mode = MODE_NONE;
        short_due = DISARMED;
        long_due = DISARMED;
      end
      if (held_mode == MODE_NONE && p.now_ms > short_due) begin
        held_mode = cur_mode;
        cur_mode = stepped(cur_mode);
        if (cur_mode == MODE_OVER) cur_mode = MODE_MED;
      end
      if (cur_mode != MODE_OVER && p.now_ms > long_due) cur_mode = MODE_OVER;
      changed |= latch_percent();
    end
    r.mode = cur_mode;
    r.throttle_percent = pct_of(cur_mode);
    r.output_changed = changed;
    return r;
  endfunction

  task automatic reset_model();
    sel_cfg.short_ms = RST_SHORT_MS;
    sel_cfg.long_ms = RST_LONG_MS;
    sel_cfg.low_pct = RST_LOW_PCT;
    sel_cfg.med_pct = RST_MED_PCT;
    sel_cfg.over_pct = RST_OVER_PCT;
    sel_cfg.brake_pct = RST_BRAKE_PCT;
    sel_cfg.brake_en = 1'b1;
    cur_mode = MODE_OFF;
    held_mode = MODE_NONE;
    short_due = DISARMED;
    long_due = DISARMED;
    last_pct = 8'd0;
  endtask

  // Output side: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (stall_left == 0 && hold_request) begin
      stall_left = LONG_HOLD;
      hold_request = 1'b0;
    end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with nothing expected, mode %0d percent %0d",
                 $time, out_mode, out_throttle_percent);
      end else begin
        want = predicted_outputs.pop_front();
        if (out_mode !== want.mode) begin
          mismatch_count++;
          $display("%0t: mode expected %0d actual %0d", $time, want.mode, out_mode);
        end
        if (out_throttle_percent !== want.throttle_percent) begin
          mismatch_count++;
          $display("%0t: throttle_percent expected %0d actual %0d",
                   $time, want.throttle_percent, out_throttle_percent);
        end
        if (out_output_changed !== want.output_changed) begin
          mismatch_count++;
          $display("%0t: output_changed expected %0d actual %0d",
                   $time, want.output_changed, out_output_changed);
        end
      end
    end
  end

  task automatic poll(logic [TIME_W-1:0] t, logic bp, logic br, logic kp, logic kr);
    item_t it;
    it.now_ms = t;
    it.button_press_edge = bp;
    it.button_release_edge = br;
    it.brake_press_edge = kp;
    it.brake_release_edge = kr;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= t;
    in_button_press_edge <= bp;
    in_button_release_edge <= br;
    in_brake_press_edge <= kp;
    in_brake_release_edge <= kr;
    do @(posedge clk); while (in_stall);
    predicted_outputs.push_back(advance_selector(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHORT_MS: sel_cfg.short_ms = value;
      REG_LONG_MS: sel_cfg.long_ms = value;
      REG_LOW_PCT: sel_cfg.low_pct = value[6:0];
      REG_MED_PCT: sel_cfg.med_pct = value[6:0];
      REG_OVER_PCT: sel_cfg.over_pct = value[6:0];
      REG_BRAKE_PCT: sel_cfg.brake_pct = value[7:0];
      REG_BRAKE_EN: sel_cfg.brake_en = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic randomize_settings(logic wide);
    logic [7:0] b;
    b = 8'(-$urandom_range(0, 100));
    write_reg(REG_SHORT_MS, wide ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 40)));
    write_reg(REG_LONG_MS, wide ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 120)));
    write_reg(REG_LOW_PCT, 16'($urandom_range(0, 100)));
    write_reg(REG_MED_PCT, 16'($urandom_range(0, 100)));
    write_reg(REG_OVER_PCT, 16'($urandom_range(0, 100)));
    write_reg(REG_BRAKE_PCT, {8'h00, b});
    write_reg(REG_BRAKE_EN, 16'($urandom_range(0, 3) != 0));
  endtask

  // Mostly press, hold, release sessions with brake activity inside them; the
  // rest are polls with random edges, some at times anywhere in the 32-bit range.
  task automatic run_sessions(int budget);
    int sent;
    int hold;
    int step_max;
    int r;
    logic brake_down;
    logic kp;
    logic kr;
    logic [TIME_W-1:0] t;
    logic [31:0] rnd;
    sent = 0;
    brake_down = 1'b0;
    while (sent < budget) begin
      if ($urandom_range(0, 40) == 0) clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
      if ($urandom_range(0, 9) < 8) begin
        step_max = int'(sel_cfg.long_ms) / 3 + 2;
        hold = $urandom_range(1, 8);
        clk_ms += $urandom_range(0, 50);
        poll(clk_ms, 1'b1, 1'b0, 1'b0, 1'b0);
        sent++;
        repeat (hold) begin
          clk_ms += $urandom_range(0, step_max);
          r = $urandom_range(0, 15);
          kp = !brake_down && r == 0;
          kr = brake_down && r < 3;
          if (kp) brake_down = 1'b1;
          if (kr) brake_down = 1'b0;
          poll(clk_ms, 1'b0, 1'b0, kp, kr);
          sent++;
        end
        clk_ms += $urandom_range(0, step_max);
        poll(clk_ms, 1'b0, 1'b1, 1'b0, 1'b0);
        sent++;
      end else begin
        rnd = $urandom;
        if (rnd[3:0] == 4'd0) t = $urandom;
        else if (rnd[3:0] == 4'd1) t = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else t = clk_ms + $urandom_range(0, 200);
        poll(t, rnd[4] & rnd[5], rnd[6] & rnd[7], rnd[8] & rnd[9], rnd[10] & rnd[11]);
        sent++;
      end
    end
  endtask

  task automatic check_default_sequences();
    poll(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd100, 1'b1, 1'b0, 1'b0, 1'b0);
    // The deadline fires only once the time is strictly past it.
    poll(32'd1100, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd1101, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd3101, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd3200, 1'b0, 1'b1, 1'b0, 1'b0);
    poll(32'd4000, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(32'd4500, 1'b0, 1'b1, 1'b0, 1'b0);
    poll(32'd5000, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(32'd6001, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd6100, 1'b0, 1'b1, 1'b0, 1'b0);
    poll(32'd7000, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(32'd8001, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd8100, 1'b0, 1'b1, 1'b0, 1'b0);
    poll(32'd9000, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(32'd10001, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(32'd12001, 1'b0, 1'b0, 1'b0, 1'b0);
    // Braking out of overdrive, then button edges while the brake is held.
    poll(32'd12100, 1'b0, 1'b0, 1'b1, 1'b0);
    poll(32'd12200, 1'b1, 1'b1, 1'b0, 1'b0);
    poll(32'd12300, 1'b0, 1'b0, 1'b0, 1'b1);
    poll(32'd12400, 1'b1, 1'b0, 1'b1, 1'b1);
    poll(32'd12500, 1'b0, 1'b0, 1'b0, 1'b1);
    poll(32'd12600, 1'b0, 1'b0, 1'b1, 1'b0);
    poll(32'd12700, 1'b0, 1'b0, 1'b1, 1'b0);
    poll(32'd12800, 1'b0, 1'b0, 1'b0, 1'b1);
    poll(32'd12900, 1'b0, 1'b0, 1'b0, 1'b1);
    // Deadlines that wrap past the top of the time range fire at once.
    poll(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic check_register_extremes();
    wait_drained();
    write_reg(REG_SHORT_MS, 16'd1);
    write_reg(REG_LONG_MS, 16'hFFFF);
    write_reg(REG_LOW_PCT, 16'd0);
    write_reg(REG_MED_PCT, 16'd100);
    write_reg(REG_OVER_PCT, 16'd0);
    write_reg(REG_BRAKE_PCT, 16'h0000);
    write_reg(REG_BRAKE_EN, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    clk_ms = 32'd20000;
    poll(clk_ms, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(clk_ms + 2, 1'b0, 1'b0, 1'b1, 1'b0);
    poll(clk_ms + 3, 1'b0, 1'b0, 1'b0, 1'b1);
    poll(clk_ms + 65536, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(clk_ms + 65600, 1'b0, 1'b1, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_SHORT_MS, 16'hFFFF);
    write_reg(REG_LONG_MS, 16'd1);
    write_reg(REG_LOW_PCT, 16'd100);
    write_reg(REG_MED_PCT, 16'd0);
    write_reg(REG_OVER_PCT, 16'd100);
    write_reg(REG_BRAKE_PCT, 16'h009C);
    write_reg(REG_BRAKE_EN, 16'd1);
    clk_ms = 32'd90000;
    poll(clk_ms, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(clk_ms + 2, 1'b0, 1'b0, 1'b0, 1'b0);
    poll(clk_ms + 3, 1'b0, 1'b0, 1'b1, 1'b0);
    poll(clk_ms + 4, 1'b0, 1'b0, 1'b0, 1'b1);
    poll(clk_ms + 5, 1'b0, 1'b1, 1'b0, 1'b0);
    poll(32'hFFFF_0000, 1'b1, 1'b0, 1'b0, 1'b0);
    poll(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic check_random_sessions();
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      randomize_settings(ph == 4);
      idle_on = (ph != 2);
      run_sessions(170);
    end
    idle_on = 1'b1;
  endtask

  task automatic check_backpressure();
    wait_drained();
    hold_request = 1'b1;
    run_sessions(40);
    wait_drained();
    run_sessions(20);
  endtask

  task automatic check_steady_stream();
    wait_drained();
    idle_on = 1'b0;
    run_sessions(100);
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_default_sequences();
    check_register_extremes();
    check_random_sessions();
    check_backpressure();
    check_steady_stream();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("[button_throttle_mode_selector] OK");
    end else begin
      $display("[button_throttle_mode_selector] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/btms_pkg.sv
src/btms_cfg.sv
src/btms_step.sv
src/button_throttle_mode_selector.sv
src/btms_checker.sv
verif/button_throttle_mode_selector_tb.sv
